@@ rtl/dq_pkg.sv @@
// Package for the double-ended queue: request and status codes, cell operations
// and the sequencer state type.
// It has no dependencies. Every other file in rtl uses it by scoped names.
package dq_pkg;

   localparam int DATA_W = 32;
   localparam int REQ_W  = 3;
   localparam int STAT_W = 2;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DUMP_FWD   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_DUMP_REV   = 3'd5;

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   // The operation that every cell of the chain performs.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_ROT_LEFT,
      CELL_ROT_RIGHT
   } cell_op_type;

   // Control sent from the sequencer to the row of cells.
   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] push_value;
   } cell_ctrl_type;

   // Sequencer state, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } seq_state_type;

endpackage

@@ rtl/dq_cell.sv @@
// One storage cell of the queue chain. Cell zero holds the front element.
// Depends on dq_pkg for the control struct and the cell operations.
module dq_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                             clock,
   input  dq_pkg::cell_ctrl_type            ctrl,
   input  logic [CNT_W-1:0]                 count,
   input  logic signed [dq_pkg::DATA_W-1:0] left_data,
   input  logic signed [dq_pkg::DATA_W-1:0] right_data,
   input  logic signed [dq_pkg::DATA_W-1:0] head_data,
   input  logic signed [dq_pkg::DATA_W-1:0] tail_data,
   output logic signed [dq_pkg::DATA_W-1:0] data,
   output logic signed [dq_pkg::DATA_W-1:0] tail_tap
);

   logic signed [dq_pkg::DATA_W-1:0] data_ff;
   logic signed [dq_pkg::DATA_W-1:0] data_in;
   logic [CNT_W-1:0]                 last_pos;
   logic                             is_first;
   logic                             is_tail;
   logic                             is_used;

   assign last_pos = count - CNT_W'(1);
   assign is_first = (IDX == 0);
   assign is_tail  = (count != '0) && (CNT_W'(IDX) == last_pos);
   assign is_used  = (CNT_W'(IDX) < count);

   // Select the next value from the neighbors according to the operation.
   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         dq_pkg::CELL_PUSH_FRONT: begin
            data_in = is_first ? ctrl.push_value : left_data;
         end
         dq_pkg::CELL_PUSH_BACK: begin
            if (CNT_W'(IDX) == count) data_in = ctrl.push_value;
         end
         dq_pkg::CELL_POP_FRONT: begin
            data_in = right_data;
         end
         dq_pkg::CELL_ROT_LEFT: begin
            if (is_tail)      data_in = head_data;
            else if (is_used) data_in = right_data;
         end
         dq_pkg::CELL_ROT_RIGHT: begin
            if (is_first)     data_in = tail_data;
            else if (is_used) data_in = left_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign tail_tap = is_tail ? data_ff : '0;

endmodule

@@ rtl/double_ended_queue.sv @@
// Double-ended queue kept as a row of shifting cells, front element in cell zero.
// Push and pop: result via pending and output registers. Unless stalled: one request
// per cycle; dump of N entries: N results at one per cycle, as the chain rotates once
// through its occupied cells; the next request is taken after the last step is issued.
// Reset (synchronous, active high) empties the queue; the cells need no clearing.
module double_ended_queue #(
   parameter  int CAPACITY = 16,
   localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dq_pkg::REQ_W-1:0]         req_type,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dq_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_item_value,
   output logic                             rsp_is_last,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_head_value,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_tail_value,
   output logic [CNT_W-1:0]                 rsp_entry_count
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   dq_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      dump_left_ff, dump_left_in;
   logic                  dump_rev_ff, dump_rev_in;

   logic                             pend_valid_ff, pend_valid_in;
   logic [dq_pkg::STAT_W-1:0]        pend_status_ff, pend_status_in;
   logic signed [dq_pkg::DATA_W-1:0] pend_item_ff, pend_item_in;
   logic                             pend_last_ff, pend_last_in;
   logic                             pend_snap_ff, pend_snap_in;

   logic signed [dq_pkg::DATA_W-1:0] snap_head_ff, snap_head_in;
   logic signed [dq_pkg::DATA_W-1:0] snap_tail_ff, snap_tail_in;

   logic                             rsp_valid_ff;
   logic [dq_pkg::STAT_W-1:0]        rsp_status_ff;
   logic signed [dq_pkg::DATA_W-1:0] rsp_item_ff;
   logic                             rsp_last_ff;
   logic signed [dq_pkg::DATA_W-1:0] rsp_head_ff;
   logic signed [dq_pkg::DATA_W-1:0] rsp_tail_ff;
   logic [CNT_W-1:0]                 rsp_count_ff;

   dq_pkg::cell_ctrl_type            cell_ctrl;
   logic signed [dq_pkg::DATA_W-1:0] cell_data [CAPACITY];
   logic signed [dq_pkg::DATA_W-1:0] cell_tail [CAPACITY];
   logic signed [dq_pkg::DATA_W-1:0] head_live;
   logic signed [dq_pkg::DATA_W-1:0] tail_live;

   logic rsp_load;
   logic pend_free;
   logic accept;
   logic dump_step;

   // Row of cells; each one reads its two neighbors and the chain ends.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [dq_pkg::DATA_W-1:0] left_nb;
      logic signed [dq_pkg::DATA_W-1:0] right_nb;
      if (i == 0) begin : g_first
         assign left_nb = req_push_value;
      end else begin : g_inner_left
         assign left_nb = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_nb = '0;
      end else begin : g_inner_right
         assign right_nb = cell_data[i+1];
      end
      dq_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .left_data  (left_nb),
         .right_data (right_nb),
         .head_data  (cell_data[0]),
         .tail_data  (tail_live),
         .data       (cell_data[i]),
         .tail_tap   (cell_tail[i])
      );
   end

   // The tail is the one cell that flags itself; all other taps are zero.
   always_comb begin
      tail_live = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_live = tail_live | cell_tail[i];
      end
   end

   assign head_live = (count_ff != '0) ? cell_data[0] : '0;

   // Handshake: the pending stage feeds the output register.
   assign rsp_load  = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pend_free = !pend_valid_ff || rsp_load;
   assign req_stall = !((state_ff == dq_pkg::ST_IDLE) && pend_free);
   assign accept    = req_valid && !req_stall;
   assign dump_step = (state_ff == dq_pkg::ST_DUMP) && pend_free;

   // Request decode and dump sequencing.
   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      dump_left_in         = dump_left_ff;
      dump_rev_in          = dump_rev_ff;
      pend_valid_in        = pend_valid_ff && !rsp_load;
      pend_status_in       = pend_status_ff;
      pend_item_in         = pend_item_ff;
      pend_last_in         = pend_last_ff;
      pend_snap_in         = pend_snap_ff;
      snap_head_in         = snap_head_ff;
      snap_tail_in         = snap_tail_ff;
      cell_ctrl.op         = dq_pkg::CELL_HOLD;
      cell_ctrl.push_value = req_push_value;

      if (accept) begin
         case (req_type)
            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
               pend_valid_in = 1'b1;
               pend_item_in  = '0;
               pend_last_in  = 1'b1;
               pend_snap_in  = 1'b0;
               if (count_ff == CAP_CNT) begin
                  pend_status_in = dq_pkg::STATUS_FULL;
               end else begin
                  pend_status_in = dq_pkg::STATUS_OK;
                  count_in       = count_ff + CNT_W'(1);
                  cell_ctrl.op   = (req_type == dq_pkg::REQ_PUSH_FRONT) ?
                                   dq_pkg::CELL_PUSH_FRONT : dq_pkg::CELL_PUSH_BACK;
               end
            end
            dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
               pend_valid_in = 1'b1;
               pend_last_in  = 1'b1;
               pend_snap_in  = 1'b0;
               if (count_ff == '0) begin
                  pend_status_in = dq_pkg::STATUS_EMPTY;
                  pend_item_in   = '0;
               end else begin
                  pend_status_in = dq_pkg::STATUS_OK;
                  count_in       = count_ff - CNT_W'(1);
                  if (req_type == dq_pkg::REQ_POP_FRONT) begin
                     pend_item_in = cell_data[0];
                     cell_ctrl.op = dq_pkg::CELL_POP_FRONT;
                  end else begin
                     pend_item_in = tail_live;
                  end
               end
            end
            dq_pkg::REQ_DUMP_FWD, dq_pkg::REQ_DUMP_REV: begin
               if (count_ff == '0) begin
                  pend_valid_in  = 1'b1;
                  pend_status_in = dq_pkg::STATUS_EMPTY;
                  pend_item_in   = '0;
                  pend_last_in   = 1'b1;
                  pend_snap_in   = 1'b0;
               end else begin
                  state_in     = dq_pkg::ST_DUMP;
                  dump_left_in = count_ff;
                  dump_rev_in  = (req_type == dq_pkg::REQ_DUMP_REV);
                  snap_head_in = head_live;
                  snap_tail_in = tail_live;
               end
            end
            default: begin
               // Unused codes are taken and dropped.
               state_in = state_ff;
            end
         endcase
      end else if (dump_step) begin
         // Emit the element at the chosen end and rotate it to the other end.
         pend_valid_in  = 1'b1;
         pend_status_in = dq_pkg::STATUS_OK;
         pend_item_in   = dump_rev_ff ? tail_live : cell_data[0];
         pend_last_in   = (dump_left_ff == CNT_W'(1));
         pend_snap_in   = 1'b1;
         cell_ctrl.op   = dump_rev_ff ? dq_pkg::CELL_ROT_RIGHT : dq_pkg::CELL_ROT_LEFT;
         dump_left_in   = dump_left_ff - CNT_W'(1);
         if (dump_left_ff == CNT_W'(1)) state_in = dq_pkg::ST_IDLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dq_pkg::ST_IDLE;
         count_ff      <= '0;
         dump_left_ff  <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dump_left_ff  <= dump_left_in;
         pend_valid_ff <= pend_valid_in;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers; the head, tail and count come from the state after the request.
   always_ff @(posedge clock) begin
      dump_rev_ff    <= dump_rev_in;
      pend_status_ff <= pend_status_in;
      pend_item_ff   <= pend_item_in;
      pend_last_ff   <= pend_last_in;
      pend_snap_ff   <= pend_snap_in;
      snap_head_ff   <= snap_head_in;
      snap_tail_ff   <= snap_tail_in;
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_item_ff   <= pend_item_ff;
         rsp_last_ff   <= pend_last_ff;
         rsp_head_ff   <= pend_snap_ff ? snap_head_ff : head_live;
         rsp_tail_ff   <= pend_snap_ff ? snap_tail_ff : tail_live;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_item_value  = rsp_item_ff;
   assign rsp_is_last     = rsp_last_ff;
   assign rsp_head_value  = rsp_head_ff;
   assign rsp_tail_value  = rsp_tail_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // The occupancy never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("queue count exceeds capacity");

   // A dump rotates the chain but never changes the occupancy.
   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::ST_DUMP) |=> $stable(count_ff))
      else $error("count changed during dump");

   // A dropped push is reported only with a full queue.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dq_pkg::STATUS_FULL) |-> (rsp_entry_count == CAP_CNT))
      else $error("full status with queue not full");

   // An empty status reports an empty queue with zero head and tail.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == dq_pkg::STATUS_EMPTY) |->
         (rsp_entry_count == '0 && rsp_head_value == '0 && rsp_tail_value == '0))
      else $error("empty status with stored entries");
`endif

endmodule

@@ dv/dq_checker.sv @@
// Checker for the double-ended queue: watches the request and result channels,
// predicts every result from a queue of its own, and compares field by field.
// Depends on dq_pkg for the request and status codes and the field widths.
`timescale 1ns / 1ps

module dq_checker #(
   parameter int CAPACITY = 16,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [dq_pkg::REQ_W-1:0]         req_type,
   input  logic signed [dq_pkg::DATA_W-1:0] req_push_value,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [dq_pkg::STAT_W-1:0]        rsp_status,
   input  logic signed [dq_pkg::DATA_W-1:0] rsp_item_value,
   input  logic                             rsp_is_last,
   input  logic signed [dq_pkg::DATA_W-1:0] rsp_head_value,
   input  logic signed [dq_pkg::DATA_W-1:0] rsp_tail_value,
   input  logic [CNT_W-1:0]                 rsp_entry_count,
   output int                               fail_count,
   output int                               request_count,
   output int                               result_count,
   output int                               outstanding
);

   typedef struct packed {
      logic [dq_pkg::STAT_W-1:0]        status;
      logic signed [dq_pkg::DATA_W-1:0] item_value;
      logic                             is_last;
      logic signed [dq_pkg::DATA_W-1:0] head_value;
      logic signed [dq_pkg::DATA_W-1:0] tail_value;
      logic [CNT_W-1:0]                 entry_count;
   } dq_result_type;

   // Queue contents as the block should hold them, front at index zero.
   logic signed [dq_pkg::DATA_W-1:0] stored_values[$];
   // Results still owed by the block, oldest first.
   dq_result_type                    expected_results[$];

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s of result %0d: got %0h, expected %0h",
               $time, what, result_count, got, want);
      fail_count++;
   endtask

   // Appends one expected result, with head, tail and count as they stand now.
   function automatic void queue_result(input logic [dq_pkg::STAT_W-1:0] status,
                                        input logic signed [dq_pkg::DATA_W-1:0] item,
                                        input logic last);
      dq_result_type r;
      r.status      = status;
      r.item_value  = item;
      r.is_last     = last;
      r.head_value  = '0;
      r.tail_value  = '0;
      r.entry_count = CNT_W'(stored_values.size());
      if (stored_values.size() != 0) begin
         r.head_value = stored_values[0];
         r.tail_value = stored_values[$];
      end
      expected_results.push_back(r);
   endfunction

   // Applies one accepted request to the queue and records the results it owes.
   function automatic void predict_request(input logic [dq_pkg::REQ_W-1:0] kind,
                                           input logic signed [dq_pkg::DATA_W-1:0] value);
      int                               n;
      int                               pos;
      logic signed [dq_pkg::DATA_W-1:0] popped;
      n = stored_values.size();
      case (kind)
         dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
            if (n >= CAPACITY) begin
               queue_result(dq_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               if (kind == dq_pkg::REQ_PUSH_FRONT)
                  stored_values.push_front(value);
               else
                  stored_values.push_back(value);
               queue_result(dq_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
            if (n == 0) begin
               queue_result(dq_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (kind == dq_pkg::REQ_POP_FRONT)
                  popped = stored_values.pop_front();
               else
                  popped = stored_values.pop_back();
               queue_result(dq_pkg::STATUS_OK, popped, 1'b1);
            end
         end
         dq_pkg::REQ_DUMP_FWD, dq_pkg::REQ_DUMP_REV: begin
            if (n == 0) begin
               queue_result(dq_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  pos = (kind == dq_pkg::REQ_DUMP_FWD) ? i : n - 1 - i;
                  queue_result(dq_pkg::STATUS_OK, stored_values[pos], i == n - 1);
               end
            end
         end
         default: ;  // Unused codes change nothing and produce no result.
      endcase
   endfunction

   // Compares one accepted result with the oldest expectation.
   task automatic check_result();
      dq_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("arrival (nothing expected), item", rsp_item_value, '0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_status !== want.status)
         report_mismatch("status", rsp_status, want.status);
      if (rsp_item_value !== want.item_value)
         report_mismatch("item_value", rsp_item_value, want.item_value);
      if (rsp_is_last !== want.is_last)
         report_mismatch("is_last", rsp_is_last, want.is_last);
      if (rsp_head_value !== want.head_value)
         report_mismatch("head_value", rsp_head_value, want.head_value);
      if (rsp_tail_value !== want.tail_value)
         report_mismatch("tail_value", rsp_tail_value, want.tail_value);
      if (rsp_entry_count !== want.entry_count)
         report_mismatch("entry_count", rsp_entry_count, want.entry_count);
   endtask

   // Both channels are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (reset) begin
         stored_values.delete();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_request(req_type, req_push_value);
            request_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            check_result();
            result_count++;
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
// Top of the double-ended queue testbench: clock, reset, request stimulus and
// result back-pressure, plus the verdict. Depends on dq_pkg, the block and dq_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int CAPACITY     = 16;
   localparam int CNT_W        = $clog2(CAPACITY + 1);
   localparam int RANDOM_ITEMS = 130;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 10;

   // Request codes the block ignores.
   localparam logic [dq_pkg::REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [dq_pkg::REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

   logic                             clock;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_stall;
   logic [dq_pkg::REQ_W-1:0]         req_type       = '0;
   logic signed [dq_pkg::DATA_W-1:0] req_push_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall      = 1'b0;
   logic [dq_pkg::STAT_W-1:0]        rsp_status;
   logic signed [dq_pkg::DATA_W-1:0] rsp_item_value;
   logic                             rsp_is_last;
   logic signed [dq_pkg::DATA_W-1:0] rsp_head_value;
   logic signed [dq_pkg::DATA_W-1:0] rsp_tail_value;
   logic [CNT_W-1:0]                 rsp_entry_count;

   int fail_count;
   int seen_requests;
   int seen_results;
   int outstanding;

   int  send_idle_pct = 8;
   int  recv_idle_pct = 75;
   bit  hold_go       = 1'b0;
   int  hold_left     = 0;
   int  sent_count    = 0;
   int  valid_ops     = 0;
   int  fill_level    = 0;
   int  stalled_cycles = 0;

   double_ended_queue #(.CAPACITY(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_is_last    (rsp_is_last),
      .rsp_head_value (rsp_head_value),
      .rsp_tail_value (rsp_tail_value),
      .rsp_entry_count(rsp_entry_count)
   );

   dq_checker #(.CAPACITY(CAPACITY)) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_is_last    (rsp_is_last),
      .rsp_head_value (rsp_head_value),
      .rsp_tail_value (rsp_tail_value),
      .rsp_entry_count(rsp_entry_count),
      .fail_count     (fail_count),
      .request_count  (seen_requests),
      .result_count   (seen_results),
      .outstanding    (outstanding)
   );

   // Free-running 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Result back-pressure: random stalls, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Cycles in which the block refused an offered request.
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall)
         stalled_cycles++;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Picks a push value, leaning on the extremes and small numbers.
   function automatic logic signed [dq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -1;
         4, 5:    return $signed(32'($urandom_range(255))) - 128;
         default: return $urandom;
      endcase
   endfunction

   // Offers one request, idling first at random, and waits until it is taken.
   task automatic send_request(input logic [dq_pkg::REQ_W-1:0] kind,
                               input logic signed [dq_pkg::DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_type       <= dq_pkg::REQ_W'($urandom);
         req_push_value <= $urandom;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sent_count++;
      // A rough occupancy count, used only to shape the bursts.
      case (kind)
         dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
            valid_ops++;
            if (fill_level < CAPACITY)
               fill_level++;
         end
         dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
            valid_ops++;
            if (fill_level > 0)
               fill_level--;
         end
         dq_pkg::REQ_DUMP_FWD, dq_pkg::REQ_DUMP_REV: valid_ops++;
         default: ;
      endcase
   endtask

   function automatic logic [dq_pkg::REQ_W-1:0] any_push();
      return $urandom_range(1) ? dq_pkg::REQ_PUSH_BACK : dq_pkg::REQ_PUSH_FRONT;
   endfunction

   function automatic logic [dq_pkg::REQ_W-1:0] any_pop();
      return $urandom_range(1) ? dq_pkg::REQ_POP_BACK : dq_pkg::REQ_POP_FRONT;
   endfunction

   function automatic logic [dq_pkg::REQ_W-1:0] any_dump();
      return $urandom_range(1) ? dq_pkg::REQ_DUMP_REV : dq_pkg::REQ_DUMP_FWD;
   endfunction

   // Stimulus: directed corners first, then random bursts in three idling phases.
   initial begin
      int n;
      int phase;
      int goal;
      int third;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, unused codes, single-element pops, extremes, both dump orders.
      send_request(dq_pkg::REQ_POP_FRONT, pick_value());
      send_request(dq_pkg::REQ_POP_BACK, pick_value());
      send_request(dq_pkg::REQ_DUMP_FWD, pick_value());
      send_request(dq_pkg::REQ_DUMP_REV, pick_value());
      send_request(REQ_UNUSED_6, 32'sh7FFF_FFFF);
      send_request(REQ_UNUSED_7, 32'sh8000_0000);
      send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(dq_pkg::REQ_POP_FRONT, '0);
      send_request(dq_pkg::REQ_PUSH_BACK, 32'sh8000_0000);
      send_request(dq_pkg::REQ_POP_BACK, '0);
      send_request(dq_pkg::REQ_PUSH_FRONT, '0);
      send_request(dq_pkg::REQ_PUSH_BACK, -1);
      send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh5555_5555);
      send_request(dq_pkg::REQ_PUSH_BACK, 32'shAAAA_AAAA);
      send_request(dq_pkg::REQ_DUMP_FWD, '0);
      send_request(dq_pkg::REQ_DUMP_REV, '0);
      send_request(dq_pkg::REQ_POP_FRONT, '0);
      send_request(dq_pkg::REQ_POP_BACK, '0);
      send_request(dq_pkg::REQ_POP_FRONT, '0);
      send_request(dq_pkg::REQ_POP_BACK, '0);
      send_request(dq_pkg::REQ_PUSH_BACK, 1);
      send_request(dq_pkg::REQ_DUMP_FWD, '0);
      send_request(dq_pkg::REQ_POP_FRONT, '0);

      // Random bursts: fills past full, drains past empty, dumps, mixes, noise.
      goal  = valid_ops + RANDOM_ITEMS;
      third = RANDOM_ITEMS / 3;
      phase = 0;
      while (valid_ops < goal) begin
         if (phase == 0 && valid_ops >= goal - 2 * third) begin
            phase         = 1;
            send_idle_pct = 75;
            recv_idle_pct = 8;
         end else if (phase == 1 && valid_ops >= goal - third) begin
            phase         = 2;
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // Hold the results back while requests keep coming, so the block backs up.
            hold_go = 1'b1;
            for (int i = 0; i < 24; i++)
               send_request((i % 4 == 3) ? any_dump() : any_push(), pick_value());
         end
         case ($urandom_range(9))
            0, 1, 2: begin
               n = CAPACITY - fill_level + $urandom_range(2);
               for (int i = 0; i < n; i++)
                  send_request(any_push(), pick_value());
               send_request(any_dump(), pick_value());
            end
            3, 4: begin
               n = fill_level + $urandom_range(2);
               for (int i = 0; i < n; i++)
                  send_request(any_pop(), pick_value());
               if ($urandom_range(1))
                  send_request(any_dump(), pick_value());
            end
            5, 6: begin
               n = 1 + $urandom_range(1);
               for (int i = 0; i < n; i++)
                  send_request(any_dump(), pick_value());
            end
            7, 8: begin
               for (int i = 0; i < 6; i++)
                  send_request(dq_pkg::REQ_W'($urandom_range(dq_pkg::REQ_DUMP_REV)),
                               pick_value());
            end
            default: begin
               send_request($urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6, $urandom);
               send_request(dq_pkg::REQ_W'($urandom_range(dq_pkg::REQ_DUMP_REV)),
                            pick_value());
            end
         endcase
      end
      req_valid     <= 1'b0;
      recv_idle_pct = 0;

      // Wait for every request to be seen and every result to come back.
      while (seen_requests != sent_count || outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d results; the input was held off for %0d cycles.",
               sent_count, seen_results, stalled_cycles);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue.sv
dv/dq_checker.sv
dv/tb_top.sv
